### hdl/ppg_motion_artifact_detector_defines.svh
// Assertion macros for the PPG motion artifact detector checker.
`ifndef PPG_MOTION_ARTIFACT_DETECTOR_DEFINES_SVH
`define PPG_MOTION_ARTIFACT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPGMAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppgmad check failed");

// Next-cycle implication, disabled while reset is asserted
`define PPGMAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppgmad check failed");

`endif

### hdl/ppgmad_pkg.sv
// Shared types and constants of the PPG motion artifact detector.
package ppgmad_pkg;

  // Datapath widths
  localparam int RMS_WIDTH      = 18;
  localparam int BASELINE_SHIFT = 6;
  localparam int MUL_B_W        = 10;
  localparam int PROD_W         = RMS_WIDTH + MUL_B_W;
  localparam int CNT_W          = $clog2(PROD_W);
  localparam int S_TDATA_W      = ((2 * RMS_WIDTH + 8 + 7) / 8) * 8;
  localparam int S_TUSER_W      = 2;
  localparam int M_TDATA_W      = 8;
  localparam int CFG_W          = 18;
  localparam int CFG_IDX_W      = 3;

  // Scoring constants
  localparam int unsigned MIN_BASELINE   = 8;
  localparam int unsigned DETECT_SCORE   = 25;
  localparam int unsigned QDROP_MIN_PREV = 45;
  localparam int unsigned QDROP_DELTA    = 30;
  localparam int unsigned SCORE_CAP      = 100;
  localparam int unsigned SPIKE_SCALE    = 100;
  localparam int unsigned RATIO_SCALE    = 1000;

  // Multiply sequence: four products, the ratio numerator, then the rounding add
  localparam logic [2:0] MUL_IR_C    = 3'd0;
  localparam logic [2:0] MUL_IR_B    = 3'd1;
  localparam logic [2:0] MUL_RED_C   = 3'd2;
  localparam logic [2:0] MUL_RED_B   = 3'd3;
  localparam logic [2:0] MUL_NUM     = 3'd4;
  localparam logic [2:0] MUL_ROUND   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_OFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_CONFIRM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CONFIRM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_RATIO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_DELTA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_HIGH = 3'd7;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### hdl/ppg_motion_artifact_detector.sv
// PPG motion artifact detector: one shared multiplier and divider under a sequencer.
// A finger-on word runs 6 multiply steps, 28 restoring divide iterations and a commit;
// a finger-off word goes straight from accept to the commit.
// One word is processed at a time: s_axis_tready is high only in the idle state.
// A new word is accepted while the previous result still waits in the output register.
// Reset (async, active low) clears all detector state and loads the default config.
module ppg_motion_artifact_detector
  import ppgmad_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input word stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // ir_rms, red_rms, quality, zero pad
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // finger_on, balance_off
  // result word stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // score, zero pad
  output logic                 m_axis_tuser   // artifact
);

  localparam int RW = RMS_WIDTH;

  // Configuration registers
  logic [6:0]         score_on_q, score_off_q;
  logic [4:0]         on_confirm_q, off_confirm_q;
  logic [MUL_B_W-1:0] spike_ratio_q;
  logic [CFG_W-1:0]   spike_delta_q;
  logic [15:0]        bal_low_q, bal_high_q;

  // Sequencer
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Detector state
  logic               seeded_q, pqv_q, motion_q;
  logic [7:0]         prev_q;
  logic [4:0]         enter_q, exit_q;
  logic [RW-1:0]      ir_base_q, red_base_q;

  // Latched input word
  logic               fin_q, bal_q;
  logic [RW-1:0]      ir_q, red_q;
  logic [7:0]         qual_q;

  // Products, divider
  logic [PROD_W-1:0]  ir_c_q, ir_b_q, red_c_q, red_b_q;
  logic [PROD_W-1:0]  num_q;
  logic [RW-1:0]      rem_q;

  // Output register
  logic               m_valid_q, m_valid_d;
  logic [6:0]         score_out_q;
  logic               art_out_q;

  logic               accept, out_free, commit;

  // Follow a target by 1/2^BASELINE_SHIFT of the gap, at least one step
  function automatic logic [RW-1:0] follow(input logic [RW-1:0] cur,
                                           input logic [RW-1:0] tgt);
    logic [RW-1:0] diff;
    logic [RW-1:0] stp;
    begin
      diff = (cur < tgt) ? (tgt - cur) : (cur - tgt);
      stp  = diff >> BASELINE_SHIFT;
      if (stp == '0) begin
        stp = RW'(1);
      end
      if (cur == tgt) begin
        follow = cur;
      end else if (cur < tgt) begin
        follow = cur + stp;
      end else begin
        follow = cur - stp;
      end
    end
  endfunction

  // Spike test against the pre-update baseline, with registered products
  function automatic logic is_spike(input logic [RW-1:0]     cur,
                                    input logic [RW-1:0]     base,
                                    input logic [PROD_W-1:0] cur_c,
                                    input logic [PROD_W-1:0] base_b,
                                    input logic [CFG_W-1:0]  min_delta);
    logic [RW-1:0] delta;
    begin
      delta    = cur - base;
      is_spike = (32'(base) >= 32'(MIN_BASELINE)) && (cur > base) &&
                 (32'(delta) >= 32'(min_delta)) && (cur_c >= base_b);
    end
  endfunction

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign commit   = (state_q == ST_DONE) && out_free;

  // Shared multiplier operand select
  logic [RW-1:0]      mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  always_comb begin
    case (cnt_q[2:0])
      MUL_IR_C:  begin mul_a = ir_q;       mul_b = MUL_B_W'(SPIKE_SCALE); end
      MUL_IR_B:  begin mul_a = ir_base_q;  mul_b = spike_ratio_q;          end
      MUL_RED_C: begin mul_a = red_q;      mul_b = MUL_B_W'(SPIKE_SCALE); end
      MUL_RED_B: begin mul_a = red_base_q; mul_b = spike_ratio_q;          end
      default:   begin mul_a = red_q;      mul_b = MUL_B_W'(RATIO_SCALE); end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring divide step
  logic [RW:0]   div_trial;
  logic          div_bit;
  logic [RW-1:0] div_rem;

  assign div_trial = {rem_q, num_q[PROD_W-1]};
  assign div_bit   = div_trial >= {1'b0, ir_q};
  assign div_rem   = div_bit ? RW'(div_trial - {1'b0, ir_q}) : RW'(div_trial);

  // Score and hysteresis for the word being committed
  logic [4:0]  on_need, off_need;
  logic        sp_ir, sp_red, bal_bad, qdrop;
  logic [2:0]  hits;
  logic [6:0]  score;
  logic [4:0]  enter_d, exit_d, ecnt, xcnt;
  logic        motion_d;
  logic        pqv_d;
  logic [RW-1:0] ir_seed, red_seed;

  always_comb begin
    on_need  = (on_confirm_q == '0) ? 5'd1 : on_confirm_q;
    off_need = (off_confirm_q == '0) ? 5'd1 : off_confirm_q;

    sp_ir   = seeded_q && is_spike(ir_q, ir_base_q, ir_c_q, ir_b_q, spike_delta_q);
    sp_red  = seeded_q && is_spike(red_q, red_base_q, red_c_q, red_b_q, spike_delta_q);
    bal_bad = bal_q || ((ir_q != '0) &&
              ((num_q < PROD_W'(bal_low_q)) || (num_q > PROD_W'(bal_high_q))));
    qdrop   = pqv_q && (prev_q >= 8'(QDROP_MIN_PREV)) &&
              (qual_q <= prev_q - 8'(QDROP_DELTA));

    hits  = 3'(sp_ir) + 3'(sp_red) + 3'(bal_bad) + 3'(qdrop);
    score = 7'(hits) * 7'(DETECT_SCORE);
    if (score > 7'(SCORE_CAP)) begin
      score = 7'(SCORE_CAP);
    end

    enter_d  = enter_q;
    exit_d   = exit_q;
    motion_d = motion_q;
    ecnt     = enter_q;
    xcnt     = exit_q;

    if (!fin_q) begin
      // no finger: score forced to zero, only exit counting runs
      score = '0;
      pqv_d = 1'b0;
      if (motion_q) begin
        xcnt = (exit_q < off_need) ? exit_q + 5'd1 : exit_q;
        if (xcnt >= off_need) begin
          motion_d = 1'b0;
          exit_d   = '0;
        end else begin
          exit_d = xcnt;
        end
      end
    end else begin
      pqv_d = 1'b1;
      if (motion_q) begin
        if (score <= score_off_q) begin
          xcnt = (exit_q < off_need) ? exit_q + 5'd1 : exit_q;
        end else begin
          xcnt = '0;
        end
        exit_d = xcnt;
        if (xcnt >= off_need) begin
          motion_d = 1'b0;
          exit_d   = '0;
          enter_d  = '0;
        end
      end else begin
        if (score >= score_on_q) begin
          ecnt = (enter_q < on_need) ? enter_q + 5'd1 : enter_q;
        end else begin
          ecnt = '0;
        end
        enter_d = ecnt;
        if (ecnt >= on_need) begin
          motion_d = 1'b1;
          enter_d  = '0;
          exit_d   = '0;
        end
      end
    end

    // first finger-on word seeds the baselines
    ir_seed  = seeded_q ? ir_base_q : ir_q;
    red_seed = seeded_q ? red_base_q : red_q;
  end

  // Next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = (m_valid_q && !m_axis_tready);
    s_axis_tready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = s_axis_tuser[0] ? ST_MUL : ST_DONE;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_q[2:0] == MUL_ROUND) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and detector state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      m_valid_q     <= 1'b0;
      score_on_q    <= 7'd75;
      score_off_q   <= 7'd30;
      on_confirm_q  <= 5'd20;
      off_confirm_q <= 5'd30;
      spike_ratio_q <= MUL_B_W'(400);
      spike_delta_q <= CFG_W'(120);
      bal_low_q     <= 16'd350;
      bal_high_q    <= 16'd2800;
      seeded_q      <= 1'b0;
      pqv_q         <= 1'b0;
      prev_q        <= '0;
      enter_q       <= '0;
      exit_q        <= '0;
      motion_q      <= 1'b0;
      ir_base_q     <= '0;
      red_base_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCORE_ON:     score_on_q    <= cfg_data_i[6:0];
          CFG_SCORE_OFF:    score_off_q   <= cfg_data_i[6:0];
          CFG_ON_CONFIRM:   on_confirm_q  <= cfg_data_i[4:0];
          CFG_OFF_CONFIRM:  off_confirm_q <= cfg_data_i[4:0];
          CFG_SPIKE_RATIO:  spike_ratio_q <= cfg_data_i[MUL_B_W-1:0];
          CFG_SPIKE_DELTA:  spike_delta_q <= cfg_data_i;
          CFG_BALANCE_LOW:  bal_low_q     <= cfg_data_i[15:0];
          CFG_BALANCE_HIGH: bal_high_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (commit) begin
        pqv_q    <= pqv_d;
        enter_q  <= enter_d;
        exit_q   <= exit_d;
        motion_q <= motion_d;
        if (fin_q) begin
          seeded_q <= 1'b1;
          prev_q   <= qual_q;
          // baselines track only while idle and below the entry score
          if (!motion_d && (score < score_on_q)) begin
            ir_base_q  <= follow(ir_seed, ir_q);
            red_base_q <= follow(red_seed, red_q);
          end else begin
            ir_base_q  <= ir_seed;
            red_base_q <= red_seed;
          end
        end
      end
    end
  end

  // Payload registers: latched word, products, divider, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fin_q  <= s_axis_tuser[0];
      bal_q  <= s_axis_tuser[1];
      ir_q   <= s_axis_tdata[RW-1:0];
      red_q  <= s_axis_tdata[2*RW-1:RW];
      qual_q <= s_axis_tdata[2*RW+7:2*RW];
    end
    if (state_q == ST_MUL) begin
      case (cnt_q[2:0])
        MUL_IR_C:  ir_c_q  <= mul_p;
        MUL_IR_B:  ir_b_q  <= mul_p;
        MUL_RED_C: red_c_q <= mul_p;
        MUL_RED_B: red_b_q <= mul_p;
        MUL_NUM:   num_q   <= mul_p;
        default: begin
          // rounding term, divider remainder starts at zero
          num_q <= num_q + PROD_W'(ir_q >> 1);
          rem_q <= '0;
        end
      endcase
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_rem;
      num_q <= {num_q[PROD_W-2:0], div_bit};
    end
    if (commit) begin
      score_out_q <= score;
      art_out_q   <= motion_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, score_out_q};
  assign m_axis_tuser  = art_out_q;

endmodule

### hdl/ppgmad_checker.sv
// Port-level checker for the PPG motion artifact detector, bound to the top level.
`include "ppg_motion_artifact_detector_defines.svh"

module ppgmad_checker
  import ppgmad_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // a stalled result word holds its value
  `PPGMAD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // score never exceeds the cap and the pad bit stays clear
  `PPGMAD_ASSERT_NOW(a_score_cap, m_axis_tvalid, m_axis_tdata <= M_TDATA_W'(SCORE_CAP))

  // one word in flight: the block goes busy right after taking a word
  `PPGMAD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind ppg_motion_artifact_detector ppgmad_checker u_ppgmad_checker (.*);

### test/tb_ppg_motion_artifact_detector.sv
// Self-checking testbench for the PPG motion artifact detector: stream driver, monitor, predictor.
module tb_ppg_motion_artifact_detector;
  import ppgmad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned RMS_MASK = (64'd1 << RMS_WIDTH) - 1;
  localparam int SCORE_W     = 7;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int SETTLE      = 48;    // quiet cycles after drain
  localparam int WATCHDOG    = 5000;  // cycles without any word moving on either side
  localparam int PHASE_WORDS = 210;

  typedef struct {
    logic                 finger;
    logic [RMS_WIDTH-1:0] ir;
    logic [RMS_WIDTH-1:0] red;
    logic [7:0]           quality;
    logic                 bal_flag;
  } ppg_metric_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               artifact;
  } verdict_t;

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // ir_rms, red_rms, quality, zero pad
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // finger_on, balance_off
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // score, zero pad
  logic                 m_axis_tuser;       // artifact

  ppg_motion_artifact_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Stimulus and expectation stores
  ppg_metric_t feed_q[$];
  verdict_t    due_verdicts[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit want_hold = 1'b0;

  int n_sent = 0;
  int n_checked = 0;
  int n_flagged = 0;
  int n_faults = 0;
  int n_phases = 0;

  // Predictor copy of the configuration
  int unsigned c_score_on, c_score_off, c_on_confirm, c_off_confirm;
  int unsigned c_spike_ratio, c_spike_delta, c_bal_low, c_bal_high;

  // Predictor copy of the detector state
  bit              bl_seeded, q_prev_ok, motion;
  int unsigned     q_prev, n_enter, n_exit;
  longint unsigned bl_ir, bl_red;

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void load_defaults();
    c_score_on = 75; c_score_off = 30; c_on_confirm = 20; c_off_confirm = 30;
    c_spike_ratio = 400; c_spike_delta = 120; c_bal_low = 350; c_bal_high = 2800;
    bl_seeded = 0; q_prev_ok = 0; motion = 0;
    q_prev = 0; n_enter = 0; n_exit = 0; bl_ir = 0; bl_red = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_SCORE_ON:     c_score_on    = data[6:0];
      CFG_SCORE_OFF:    c_score_off   = data[6:0];
      CFG_ON_CONFIRM:   c_on_confirm  = data[4:0];
      CFG_OFF_CONFIRM:  c_off_confirm = data[4:0];
      CFG_SPIKE_RATIO:  c_spike_ratio = data[9:0];
      CFG_SPIKE_DELTA:  c_spike_delta = data[17:0];
      CFG_BALANCE_LOW:  c_bal_low     = data[15:0];
      CFG_BALANCE_HIGH: c_bal_high    = data[15:0];
      default: ;
    endcase
  endfunction

  // Spike: big enough rise over a usable baseline, in both absolute and ratio terms
  function automatic bit spike_hit(longint unsigned cur, longint unsigned base);
    if (base < MIN_BASELINE || cur <= base || (cur - base) < c_spike_delta)
      return 1'b0;
    return (cur * SPIKE_SCALE) >= (base * c_spike_ratio);
  endfunction

  // Baseline moves 1/2^shift of the gap, at least one count
  function automatic longint unsigned track(longint unsigned cur, longint unsigned tgt);
    longint unsigned step;
    if (cur == tgt) return cur;
    if (cur < tgt) begin
      step = (tgt - cur) >> BASELINE_SHIFT;
      return cur + ((step == 0) ? 1 : step);
    end
    step = (cur - tgt) >> BASELINE_SHIFT;
    return cur - ((step == 0) ? 1 : step);
  endfunction

  // Score one metrics word and advance the hysteresis state
  function automatic verdict_t score_metrics(ppg_metric_t m);
    int unsigned     need_on, need_off, pts;
    bit              bad_bal;
    longint unsigned ir, red, ratio;
    verdict_t        v;
    need_on  = (c_on_confirm == 0) ? 1 : c_on_confirm;
    need_off = (c_off_confirm == 0) ? 1 : c_off_confirm;
    pts = 0;
    bad_bal = m.bal_flag;
    ir = m.ir;
    red = m.red;

    // finger lifted: only exit counting runs
    if (!m.finger) begin
      q_prev_ok = 1'b0;
      if (motion) begin
        if (n_exit < need_off) n_exit++;
        if (n_exit >= need_off) begin
          motion = 1'b0;
          n_exit = 0;
        end
      end
      v.score = '0;
      v.artifact = motion;
      return v;
    end

    if (!bl_seeded) begin
      bl_ir = ir;
      bl_red = red;
      bl_seeded = 1'b1;
    end else begin
      if (spike_hit(ir, bl_ir)) pts += DETECT_SCORE;
      if (spike_hit(red, bl_red)) pts += DETECT_SCORE;
    end

    // rounded RED/IR x1000, full width
    if (ir != 0) begin
      ratio = (red * RATIO_SCALE + (ir >> 1)) / ir;
      if (ratio < c_bal_low || ratio > c_bal_high) bad_bal = 1'b1;
    end
    if (bad_bal) pts += DETECT_SCORE;

    if (q_prev_ok && q_prev >= QDROP_MIN_PREV && m.quality <= q_prev - QDROP_DELTA)
      pts += DETECT_SCORE;

    if (pts > SCORE_CAP) pts = SCORE_CAP;

    if (motion) begin
      if (pts <= c_score_off) begin
        if (n_exit < need_off) n_exit++;
      end else begin
        n_exit = 0;
      end
      if (n_exit >= need_off) begin
        motion = 1'b0;
        n_exit = 0;
        n_enter = 0;
      end
    end else begin
      if (pts >= c_score_on) begin
        if (n_enter < need_on) n_enter++;
      end else begin
        n_enter = 0;
      end
      if (n_enter >= need_on) begin
        motion = 1'b1;
        n_enter = 0;
        n_exit = 0;
      end
    end

    if (!motion && pts < c_score_on) begin
      bl_ir = track(bl_ir, ir);
      bl_red = track(bl_red, red);
    end

    q_prev = m.quality;
    q_prev_ok = 1'b1;

    v.score = pts[SCORE_W-1:0];
    v.artifact = motion;
    return v;
  endfunction

  // Queue one word, clamping fields to their widths
  task automatic push_metric(input bit f, input longint unsigned ir, input longint unsigned red,
                             input int q, input bit b);
    ppg_metric_t m;
    if (ir > RMS_MASK) ir = RMS_MASK;
    if (red > RMS_MASK) red = RMS_MASK;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    m.finger = f;
    m.ir = ir[RMS_WIDTH-1:0];
    m.red = red[RMS_WIDTH-1:0];
    m.quality = q[7:0];
    m.bal_flag = b;
    feed_q.push_back(m);
  endtask

  // Steady signal near a level, ratio in a plausible range
  task automatic push_calm(input longint unsigned lvl, input longint unsigned rk, input int q0);
    longint unsigned ir;
    ir = lvl + $urandom_range(0, int'(lvl / 16) + 1);
    push_metric(1'b1, ir, ir * rk / 1000, q0 - int'($urandom_range(0, 5)),
                ($urandom_range(19) == 0));
  endtask

  // Mostly calm/burst/calm episodes with random content, plus noise and finger-off runs
  task automatic gen_traffic(input int n);
    int              made, pick, len, i, q0, qv;
    longint unsigned lvl, rk, ir, red;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++)
          push_metric($urandom_range(1), $urandom & RMS_MASK, $urandom & RMS_MASK,
                      $urandom_range(255), $urandom_range(1));
        made += len;
      end else if (pick < 20) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++)
          push_metric(1'b0, $urandom & RMS_MASK, $urandom & RMS_MASK,
                      $urandom_range(255), $urandom_range(1));
        made += len;
      end else begin
        lvl = ($urandom_range(9) == 0) ? $urandom_range(0, 12) : $urandom_range(16, 40000);
        rk = $urandom_range(400, 2500);
        q0 = $urandom_range(50, 255);
        len = $urandom_range(2, 12);
        for (i = 0; i < len; i++) push_calm(lvl, rk, q0);
        made += len;
        // artifact burst: spikes, quality dips, balance faults
        len = $urandom_range(1, 32);
        for (i = 0; i < len; i++) begin
          ir = $urandom_range(1) ? lvl * $urandom_range(3, 12) + $urandom_range(0, 4000) : lvl;
          red = lvl * rk / 1000;
          if ($urandom_range(1)) red = red * $urandom_range(3, 12) + $urandom_range(0, 4000);
          qv = (i % 2 == 0) ? q0 - int'($urandom_range(30, 35)) : q0;
          push_metric(1'b1, ir, red, qv, ($urandom_range(2) == 0));
        end
        made += len;
        len = $urandom_range(2, 36);
        for (i = 0; i < len; i++) push_calm(lvl, rk, q0);
        made += len;
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    apply_cfg(idx, data);
  endtask

  task automatic set_all(input int unsigned son, input int unsigned soff, input int unsigned onc,
                         input int unsigned offc, input int unsigned rat, input int unsigned dlt,
                         input int unsigned blo, input int unsigned bhi);
    cfg_write(CFG_SCORE_ON, CFG_W'(son));
    cfg_write(CFG_SCORE_OFF, CFG_W'(soff));
    cfg_write(CFG_ON_CONFIRM, CFG_W'(onc));
    cfg_write(CFG_OFF_CONFIRM, CFG_W'(offc));
    cfg_write(CFG_SPIKE_RATIO, CFG_W'(rat));
    cfg_write(CFG_SPIKE_DELTA, CFG_W'(dlt));
    cfg_write(CFG_BALANCE_LOW, CFG_W'(blo));
    cfg_write(CFG_BALANCE_HIGH, CFG_W'(bhi));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_random_in_range();
    set_all($urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(1, 31),
            $urandom_range(1, 31), $urandom_range(100, 1000), $urandom_range(0, 2000),
            $urandom_range(0, 1200), $urandom_range(1200, 65535));
  endtask

  // Wait until every word went in and every result came out, then let the block settle
  task automatic drain();
    while (feed_q.size() != 0 || s_axis_tvalid || due_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(input int mode, input bit squeeze);
    case (mode)
      0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      1: begin src_idle_pct = 64; snk_idle_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_idle_pct = 64; end
      default: begin src_idle_pct = 14; snk_idle_pct = 14; end
    endcase
    gen_traffic(PHASE_WORDS);
    if (squeeze) want_hold = 1'b1;
    drain();
    n_phases++;
  endtask

  task automatic note_fault();
    n_faults++;
  endtask

  // Compare one result word with the oldest expectation
  task automatic check_result(input logic [SCORE_W-1:0] got_score, input logic got_art);
    verdict_t want;
    if (due_verdicts.size() == 0) begin
      note_fault();
      if (n_faults <= 10)
        $display("[%0t] unexpected result: score %0d artifact %0b", $realtime, got_score,
                 got_art);
    end else begin
      want = due_verdicts.pop_front();
      n_checked++;
      if (got_art === 1'b1) n_flagged++;
      if (got_score !== want.score || got_art !== want.artifact) begin
        note_fault();
        if (n_faults <= 10)
          $display("[%0t] result %0d mismatch: score exp %0d got %0d, artifact exp %0b got %0b",
                   $realtime, n_checked, want.score, got_score, want.artifact, got_art);
      end
    end
  endtask

  // Driver: predict on accept, then offer the next word or idle
  ppg_metric_t cur_word;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_verdicts.push_back(score_metrics(cur_word));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_word = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_TDATA_W'({cur_word.quality, cur_word.red, cur_word.ir});
          s_axis_tuser <= {cur_word.bal_flag, cur_word.finger};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results, random stalls, one long hold-off
  int hold_left;
  bit hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata[SCORE_W-1:0], m_axis_tuser);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (want_hold && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on cycles where no word moves on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sequence: reset, directed words on defaults, then configured random phases
  initial begin
    int p;
    load_defaults();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // finger off before any seed
    push_metric(1'b0, RMS_MASK, RMS_MASK, 255, 1'b1);
    // first valid word seeds tiny baselines, too small for a spike on the next word
    push_metric(1'b1, 5, 5, 200, 1'b0);
    push_metric(1'b1, RMS_MASK, RMS_MASK, 200, 1'b0);
    push_metric(1'b1, 1000, 1000, 200, 1'b0);
    // both channels spike
    push_metric(1'b1, RMS_MASK, RMS_MASK, 255, 1'b0);
    // zero IR: no ratio test; a quality drop, then a red spike with the balance flag set
    push_metric(1'b1, 0, 0, 0, 1'b0);
    push_metric(1'b1, 0, RMS_MASK, 0, 1'b1);
    // ratio zero, then a huge unclipped ratio with a drop of 31
    push_metric(1'b1, RMS_MASK, 0, 255, 1'b0);
    push_metric(1'b1, 1, RMS_MASK, 224, 1'b0);
    // ratio edges: 350 and 2800 in range, 349, 2801 and rounded 333 out
    push_metric(1'b1, 1000, 350, 194, 1'b0);
    push_metric(1'b1, 1000, 2800, 194, 1'b0);
    push_metric(1'b1, 1000, 349, 194, 1'b0);
    push_metric(1'b1, 1000, 2801, 194, 1'b0);
    push_metric(1'b1, 3, 1, 194, 1'b0);
    // quality drop of exactly 30 from 45, none from 44
    push_metric(1'b1, 1000, 1000, 45, 1'b0);
    push_metric(1'b1, 1000, 1000, 15, 1'b0);
    push_metric(1'b1, 1000, 1000, 44, 1'b0);
    push_metric(1'b1, 1000, 1000, 0, 1'b0);
    // finger off clears the previous quality
    push_metric(1'b1, 1000, 1000, 255, 1'b0);
    push_metric(1'b0, 0, 0, 0, 1'b0);
    push_metric(1'b1, 1000, 1000, 0, 1'b1);
    drain();

    for (p = 1; p <= 8; p++) begin
      case (p)
        1: set_all(50, 25, 3, 4, 300, 50, 500, 2000);
        2: set_all(0, 0, 0, 0, 0, 0, 0, 0);
        3: set_all(100, 100, 31, 31, 1000, 32'(RMS_MASK), 65535, 65535);
        5: set_all(25, 0, 1, 1, 100, 0, 0, 65535);
        6: set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
        8: set_all(75, 30, 20, 30, 400, 120, 350, 2800);
        default: set_random_in_range();
      endcase
      run_phase((p - 1) % 4, (p == 1));
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d metric words over %0d configured phases plus directed cases;",
             n_sent, n_phases);
    $display("checked %0d results, %0d with artifact set, %0d mismatches.",
             n_checked, n_flagged, n_faults);
    if (n_faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
